@@ src/assert_macros.svh @@
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define DSBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define DSBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/dsbe_pkg.sv @@
// types, constants and decay table for the debounced switch bell envelope unit
`default_nettype none
package dsbe_pkg;

  // event codes
  typedef enum logic [1:0] {
    OP_SCAN      = 2'd0,
    OP_BELL      = 2'd1,
    OP_CLR_PRESS = 2'd2,
    OP_CLR_BELL  = 2'd3
  } dsbe_op_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BELL_DURATION  = 3'd0,
    CFG_BELL_START_LVL = 3'd1,
    CFG_PRESS_LVL      = 3'd2,
    CFG_RELEASE_DEPTH  = 3'd3,
    CFG_DEBOUNCE_START = 3'd4
  } dsbe_cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] BELL_DURATION_RST  = 16'd20000;
  localparam logic [7:0]  BELL_START_LVL_RST = 8'd10;
  localparam logic [7:0]  PRESS_LVL_RST      = 8'd40;
  localparam logic [7:0]  RELEASE_DEPTH_RST  = 8'd20;
  localparam logic [7:0]  DEBOUNCE_START_RST = 8'd29;

  // debounce and bell constants
  localparam logic [7:0]  CNT_MAX      = 8'd255;
  localparam logic [4:0]  PWM_LAST     = 5'd18;
  localparam logic [3:0]  START_DUTY   = 4'd15;
  localparam logic [16:0] ENV_OFFSET   = 17'd10000;
  localparam int          ENV_SHIFT    = 9;
  localparam int          ENVELOPE_ENTRIES = 98;
  localparam int          ROM_SPACE    = 128;
  localparam int          ROM_IDX_W    = $clog2(ROM_SPACE);
  localparam logic [7:0]  ENV_LAST     = 8'(ENVELOPE_ENTRIES - 1);

  // decay envelope, indexed by remaining ring count
  localparam logic [3:0] DECAY_ROM [ROM_SPACE] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9,
    4'd9, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12,
    4'd12, 4'd13, 4'd13, 4'd13, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  // input item
  typedef struct packed {
    dsbe_op_t operation;
    logic     switch_low;
  } dsbe_in_t;

  // result item
  typedef struct packed {
    logic pressed_flag;
    logic bell_active;
    logic speaker_on;
    logic green_lamp;
  } dsbe_out_t;

  // live configuration seen by the core
  typedef struct packed {
    logic [15:0] bell_duration;
    logic [7:0]  bell_start_level;
    logic [7:0]  press_level;
    logic [7:0]  release_depth;
  } dsbe_cfg_t;

endpackage
`default_nettype wire

@@ src/debounced_switch_bell_envelope_unit.sv @@
// top level: input register, state update core, result register and config port
// One event enters per cycle unless the input stalls; after its transfer the
// event sits in the input register while the state update writes its status
// result into the result register. Throughput is one event per clock, limited
// only by the output stall; the input stalls only when both registers hold
// undelivered items. Scan ticks run the debounce counter, bell ticks step the
// pwm phase and the decay envelope, and the two clear events drop the press or
// bell flag. Configuration writes are always ready and should be issued while
// no event is in flight; writes to the debounce start index have no effect.
`default_nettype none
module debounced_switch_bell_envelope_unit
  import dsbe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire dsbe_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output dsbe_out_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic      s1_valid_r, s1_valid_nxt;
  dsbe_in_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  dsbe_out_t out_data_r;
  dsbe_out_t result;
  dsbe_cfg_t cfg;
  logic      advance;
  logic      in_xfer;

  // handshake control
  assign advance       = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = s1_valid_r & ~advance;
  assign in_xfer       = in_valid & ~in_stall;
  assign s1_valid_nxt  = in_xfer | (s1_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & out_stall);
  assign cfg_ready     = 1'b1;

  dsbe_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dsbe_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `DSBE_ASSERT_ALWAYS(a_stall_needs_item, !s1_valid_r |-> !in_stall,
    "stall with empty input register")
  `DSBE_ASSERT(a_advance_fills_out, advance |=> out_valid_r,
    "advanced item missing at output")
  `DSBE_ASSERT(a_drain_empties,
    (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r,
    "result repeated after transfer")
  `DSBE_ASSERT(a_ring_has_lamp,
    out_valid_r |-> (!out_data_r.bell_active || out_data_r.green_lamp),
    "bell ringing with lamp off")

endmodule
`default_nettype wire

@@ src/dsbe_cfg_regs.sv @@
// configuration register file
`default_nettype none
module dsbe_cfg_regs
  import dsbe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output dsbe_cfg_t                  cfg
);

  dsbe_cfg_t cfg_r;
  dsbe_cfg_t cfg_nxt;

  // index decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_BELL_DURATION:  cfg_nxt.bell_duration    = wr_data;
        CFG_BELL_START_LVL: cfg_nxt.bell_start_level = wr_data[7:0];
        CFG_PRESS_LVL:      cfg_nxt.press_level      = wr_data[7:0];
        CFG_RELEASE_DEPTH:  cfg_nxt.release_depth    = wr_data[7:0];
        // counter start writes are ignored; the counter resets to a fixed package value
        CFG_DEBOUNCE_START: cfg_nxt = cfg_r;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bell_duration    <= BELL_DURATION_RST;
      cfg_r.bell_start_level <= BELL_START_LVL_RST;
      cfg_r.press_level      <= PRESS_LVL_RST;
      cfg_r.release_depth    <= RELEASE_DEPTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ src/dsbe_core.sv @@
// debounce counter, bell envelope and pwm state update
`default_nettype none
module dsbe_core
  import dsbe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire dsbe_in_t  item,
  input  wire dsbe_cfg_t cfg,
  output dsbe_out_t      result
);

  logic [7:0]  cnt_r, cnt_nxt;
  logic        latched_r, latched_nxt;
  logic        ringing_r, ringing_nxt;
  logic        drive_r, drive_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [4:0]  phase_r, phase_nxt;
  logic [3:0]  duty_r, duty_nxt;
  logic        lamp_r, lamp_nxt;

  logic [7:0]           cnt_up;
  logic [7:0]           cnt_dn;
  logic [7:0]           rel_level;
  logic [4:0]           phase_inc;
  logic [16:0]          env_sum;
  logic [7:0]           env_raw;
  logic [7:0]           env_sat;
  logic [ROM_IDX_W-1:0] env_idx;
  logic [3:0]           env_duty;

  // saturating counter steps and envelope lookup
  always_comb begin
    cnt_up    = (cnt_r != CNT_MAX) ? cnt_r + 8'd1 : cnt_r;
    cnt_dn    = (cnt_r != 8'd0) ? cnt_r - 8'd1 : cnt_r;
    rel_level = CNT_MAX - cfg.release_depth;
    phase_inc = (phase_r >= PWM_LAST) ? 5'd0 : phase_r + 5'd1;
    env_sum   = {1'b0, rem_r} + ENV_OFFSET;
    env_raw   = 8'(env_sum >> ENV_SHIFT);
    env_sat   = (env_raw > ENV_LAST) ? ENV_LAST : env_raw;
    env_idx   = env_sat[ROM_IDX_W-1:0];
    env_duty  = DECAY_ROM[env_idx];
  end

  // next state per event
  always_comb begin
    cnt_nxt     = cnt_r;
    latched_nxt = latched_r;
    ringing_nxt = ringing_r;
    drive_nxt   = drive_r;
    rem_nxt     = rem_r;
    phase_nxt   = phase_r;
    duty_nxt    = duty_r;
    lamp_nxt    = lamp_r;
    unique case (item.operation)
      OP_SCAN: begin
        if (item.switch_low) begin
          cnt_nxt = cnt_up;
          // bell start check runs before the press check
          if (cnt_up == cfg.bell_start_level) begin
            ringing_nxt = 1'b1;
            drive_nxt   = 1'b1;
            rem_nxt     = cfg.bell_duration;
            phase_nxt   = 5'd0;
            duty_nxt    = START_DUTY;
            lamp_nxt    = 1'b1;
          end
          if (cnt_up == cfg.press_level) begin
            cnt_nxt     = CNT_MAX;
            latched_nxt = 1'b1;
            ringing_nxt = 1'b0;
            drive_nxt   = 1'b0;
            rem_nxt     = 16'd0;
            phase_nxt   = 5'd0;
            lamp_nxt    = 1'b0;
          end
        end else begin
          cnt_nxt = cnt_dn;
          // release restarts the bell
          if (cnt_dn == rel_level) begin
            cnt_nxt     = 8'd0;
            latched_nxt = 1'b0;
            ringing_nxt = 1'b1;
            drive_nxt   = 1'b1;
            rem_nxt     = cfg.bell_duration;
            phase_nxt   = 5'd0;
            duty_nxt    = START_DUTY;
            lamp_nxt    = 1'b1;
          end
        end
      end
      OP_BELL: begin
        if (!latched_r && ringing_r) begin
          phase_nxt = phase_inc;
          drive_nxt = (phase_inc < {1'b0, duty_r});
          duty_nxt  = env_duty;
          if (rem_r != 16'd0) begin
            rem_nxt = rem_r - 16'd1;
          end else begin
            // ring period over
            ringing_nxt = 1'b0;
            drive_nxt   = 1'b0;
            phase_nxt   = 5'd0;
            lamp_nxt    = 1'b0;
          end
        end
      end
      OP_CLR_PRESS: latched_nxt = 1'b0;
      OP_CLR_BELL:  ringing_nxt = 1'b0;
      default: ;
    endcase
  end

  // state registers, updated once per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= DEBOUNCE_START_RST;
      latched_r <= 1'b0;
      ringing_r <= 1'b0;
      drive_r   <= 1'b0;
      rem_r     <= 16'd0;
      phase_r   <= 5'd0;
      duty_r    <= 4'd0;
      lamp_r    <= 1'b0;
    end else if (step) begin
      cnt_r     <= cnt_nxt;
      latched_r <= latched_nxt;
      ringing_r <= ringing_nxt;
      drive_r   <= drive_nxt;
      rem_r     <= rem_nxt;
      phase_r   <= phase_nxt;
      duty_r    <= duty_nxt;
      lamp_r    <= lamp_nxt;
    end
  end

  // status after the update
  always_comb begin
    result.pressed_flag = latched_nxt;
    result.bell_active  = ringing_nxt;
    result.speaker_on   = drive_nxt;
    result.green_lamp   = lamp_nxt;
  end

endmodule
`default_nettype wire
